// ----- rtl/dlp_pkg.sv -----
// ----------------------------------------------------------------------------
// dlp_pkg
// Shared types and constants for the debounced long-press detector: event
// codes, configuration register indexes, reset values and the constants of
// the divide-by-1000 reciprocal.
// ----------------------------------------------------------------------------
package dlp_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int DEB_W    = 16;
    localparam int SEC_W    = 8;
    localparam int CODE_W   = 3;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 16;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;
    localparam int IN_W     = TIME_W + 2;   // poll fields held in the input register

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_DEBOUNCE_TIME = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_HOLD_SECONDS  = 1'b1;

    // configuration reset values
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [SEC_W-1:0] HOLD_SECONDS_RESET = 8'd5;

    // floor(d / 1000) = floor((d >> 3) * SEC_RECIP >> SEC_POST_SHIFT)
    // for any 32-bit d; SEC_RECIP = ceil(2^36 / 125)
    localparam int SEC_PRE_SHIFT  = 3;
    localparam int SEC_DIV_IN_W   = TIME_W - SEC_PRE_SHIFT;
    localparam int SEC_RECIP_W    = 30;
    localparam int SEC_PROD_W     = SEC_DIV_IN_W + SEC_RECIP_W;
    localparam int SEC_POST_SHIFT = 36;
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = 30'd549755814;

    // result event codes
    typedef enum logic [CODE_W-1:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_SECOND  = 3'd3,
        EV_PORTAL  = 3'd4
    } event_code_t;

    // poll after debouncing and the divide, waiting for the hold controller
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              portal_active;
        logic              stable_level;
        logic [SEC_W-1:0]  held_cur;   // seconds since the stored hold start
        logic [SEC_W-1:0]  held_fwd;   // seconds since the previous poll
        logic              fresh;      // previous poll was one stage ahead
    } stage_t;

    // one result item
    typedef struct packed {
        logic              stable_level;
        logic [SEC_W-1:0]  second_value;
        event_code_t       event_code;
    } result_t;

endpackage

// ----- rtl/debounced_long_press_detector.sv -----
// ----------------------------------------------------------------------------
// debounced_long_press_detector
// Push-button poll processor: debounce, hold-second reporting and portal
// request, one result per poll.
// ----------------------------------------------------------------------------
// Takes one poll per clock cycle while the output is not stalled and gives
// exactly one result per poll, in order, on m_tdata. Polls pass an input
// register, a stage that debounces and turns both candidate hold times into
// whole seconds (one reciprocal multiply each, since the hold start may be
// moved by the poll just ahead), a stage that runs the hold tracking, and the
// output register. Back-pressure on m_tready stalls the whole pipe; s_tready
// stays high while any stage is free. Configuration writes take effect at
// once and should be made while no poll is in flight.
// ----------------------------------------------------------------------------
module debounced_long_press_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    // poll stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dlp_pkg::S_DATA_W-1:0]    s_tdata,   // now_ms[31:0], raw_pressed, portal_active
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dlp_pkg::M_DATA_W-1:0]    m_tdata,   // event_code[2:0], second_value[7:0], stable_level
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [dlp_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [dlp_pkg::CFG_DW-1:0]      cfg_wdata
);

    logic [dlp_pkg::DEB_W-1:0]  debounce_time_reg;
    logic [dlp_pkg::SEC_W-1:0]  hold_seconds_reg;

    logic                       p1_valid_reg;
    logic [dlp_pkg::IN_W-1:0]   p1_data_reg;
    logic                       p2_valid_reg;
    dlp_pkg::stage_t            p2_reg;
    dlp_pkg::stage_t            p2_next;
    logic                       out_valid_reg;
    dlp_pkg::result_t           out_reg;

    logic                       out_free;
    logic                       p2_free;
    logic                       fire_a;
    logic                       fire_b;
    logic [dlp_pkg::TIME_W-1:0] p1_now;
    logic                       p1_raw;
    logic                       p1_portal;
    logic                       stable_level;
    logic [dlp_pkg::TIME_W-1:0] hold_start;
    logic [dlp_pkg::TIME_W-1:0] diff_cur;
    logic [dlp_pkg::TIME_W-1:0] diff_fwd;
    logic [dlp_pkg::SEC_W-1:0]  held_cur;
    logic [dlp_pkg::SEC_W-1:0]  held_fwd;
    dlp_pkg::result_t           result;

    // pipeline flow control
    assign out_free = !out_valid_reg || m_tready;
    assign p2_free  = !p2_valid_reg || out_free;
    assign fire_a   = p1_valid_reg && p2_free;
    assign fire_b   = p2_valid_reg && out_free;
    assign s_tready = !p1_valid_reg || p2_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg <= dlp_pkg::DEBOUNCE_RESET;
            hold_seconds_reg  <= dlp_pkg::HOLD_SECONDS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                dlp_pkg::CFG_DEBOUNCE_TIME: debounce_time_reg <= cfg_wdata;
                dlp_pkg::CFG_HOLD_SECONDS:  hold_seconds_reg  <= cfg_wdata[dlp_pkg::SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            p1_data_reg <= s_tdata[dlp_pkg::IN_W-1:0];
        end
    end

    assign p1_now    = p1_data_reg[dlp_pkg::TIME_W-1:0];
    assign p1_raw    = p1_data_reg[dlp_pkg::TIME_W];
    assign p1_portal = p1_data_reg[dlp_pkg::TIME_W+1];

    // stage a: debounce, and seconds since the hold start and since the previous poll
    dlp_debounce u_debounce (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .fire             (fire_a),
        .now_ms           (p1_now),
        .raw_pressed      (p1_raw),
        .portal_active    (p1_portal),
        .debounce_time_ms (debounce_time_reg),
        .stable_level     (stable_level)
    );

    assign diff_cur = p1_now - hold_start;
    assign diff_fwd = p1_now - p2_reg.now_ms;

    dlp_sec_div u_div_cur (
        .diff_ms (diff_cur),
        .seconds (held_cur)
    );

    dlp_sec_div u_div_fwd (
        .diff_ms (diff_fwd),
        .seconds (held_fwd)
    );

    always_comb begin
        p2_next.now_ms        = p1_now;
        p2_next.portal_active = p1_portal;
        p2_next.stable_level  = stable_level;
        p2_next.held_cur      = held_cur;
        p2_next.held_fwd      = held_fwd;
        p2_next.fresh         = p2_valid_reg;
    end

    // stage register between debounce and hold tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_free) begin
            p2_valid_reg <= fire_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_a) begin
            p2_reg <= p2_next;
        end
    end

    // stage b: hold tracking
    dlp_hold_ctrl u_hold_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire_b),
        .stage        (p2_reg),
        .hold_seconds (hold_seconds_reg),
        .hold_start   (hold_start),
        .result       (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_b) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dlp_pkg::M_DATA_W-$bits(dlp_pkg::result_t)){1'b0}}, out_reg};

endmodule

// ----- rtl/dlp_debounce.sv -----
// ----------------------------------------------------------------------------
// dlp_debounce
// Time-based debouncer. The raw level becomes the stable level once it has
// stayed unchanged for the debounce time. Frozen while the portal is active.
// ----------------------------------------------------------------------------
module dlp_debounce (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  logic [dlp_pkg::TIME_W-1:0]    now_ms,
    input  logic                          raw_pressed,
    input  logic                          portal_active,
    input  logic [dlp_pkg::DEB_W-1:0]     debounce_time_ms,
    output logic                          stable_level
);

    logic                       prev_raw_reg;
    logic                       prev_raw_next;
    logic                       level_reg;
    logic                       level_next;
    logic [dlp_pkg::TIME_W-1:0] last_change_reg;
    logic [dlp_pkg::TIME_W-1:0] last_change_next;
    logic [dlp_pkg::TIME_W-1:0] since_change;

    assign since_change = now_ms - last_change_reg;

    // next debouncer state for this poll
    always_comb begin
        prev_raw_next    = prev_raw_reg;
        level_next       = level_reg;
        last_change_next = last_change_reg;
        priority if (portal_active) begin
            // frozen
        end else if (raw_pressed != prev_raw_reg) begin
            prev_raw_next    = raw_pressed;
            last_change_next = now_ms;
        end else if (since_change >= {{(dlp_pkg::TIME_W-dlp_pkg::DEB_W){1'b0}},
                                      debounce_time_ms}) begin
            level_next = raw_pressed;
        end
    end

    assign stable_level = level_next;

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg    <= 1'b0;
            level_reg       <= 1'b0;
            last_change_reg <= '0;
        end else if (fire) begin
            prev_raw_reg    <= prev_raw_next;
            level_reg       <= level_next;
            last_change_reg <= last_change_next;
        end
    end

endmodule

// ----- rtl/dlp_sec_div.sv -----
// ----------------------------------------------------------------------------
// dlp_sec_div
// Whole seconds of a millisecond difference, truncated to 8 bits, by a
// shift by 3 and a multiply with the reciprocal of 125.
// ----------------------------------------------------------------------------
module dlp_sec_div (
    input  logic [dlp_pkg::TIME_W-1:0] diff_ms,
    output logic [dlp_pkg::SEC_W-1:0]  seconds
);

    logic [dlp_pkg::SEC_DIV_IN_W-1:0] eighths;
    logic [dlp_pkg::SEC_PROD_W-1:0]   prod;

    // divide by 8 first, then by 125 through the reciprocal
    assign eighths = diff_ms[dlp_pkg::TIME_W-1:dlp_pkg::SEC_PRE_SHIFT];
    assign prod    = dlp_pkg::SEC_PROD_W'(eighths) * dlp_pkg::SEC_PROD_W'(dlp_pkg::SEC_RECIP);
    assign seconds = prod[dlp_pkg::SEC_POST_SHIFT +: dlp_pkg::SEC_W];

endmodule

// ----- rtl/dlp_hold_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlp_hold_ctrl
// Hold tracking: press start, at most one reported second per poll, portal request
// at the hold-seconds setting, and early release.
// ----------------------------------------------------------------------------
module dlp_hold_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  dlp_pkg::stage_t               stage,
    input  logic [dlp_pkg::SEC_W-1:0]     hold_seconds,
    output logic [dlp_pkg::TIME_W-1:0]    hold_start,
    output dlp_pkg::result_t              result
);

    logic                       hold_active_reg;
    logic                       hold_active_next;
    logic [dlp_pkg::TIME_W-1:0] hold_start_reg;
    logic [dlp_pkg::TIME_W-1:0] hold_start_next;
    logic [dlp_pkg::SEC_W-1:0]  last_sec_reg;
    logic [dlp_pkg::SEC_W-1:0]  last_sec_next;
    logic                       press_started_reg;
    logic [dlp_pkg::SEC_W-1:0]  held;
    logic [dlp_pkg::SEC_W:0]    next_sec;
    dlp_pkg::event_code_t       ev;
    logic [dlp_pkg::SEC_W-1:0]  sec;

    // a press started by the poll just ahead moved the hold start to its
    // timestamp, so the forwarded quotient applies
    assign held     = (stage.fresh && press_started_reg) ? stage.held_fwd : stage.held_cur;
    assign next_sec = {1'b0, last_sec_reg} + {{dlp_pkg::SEC_W{1'b0}}, 1'b1};

    // hold decision
    always_comb begin
        hold_active_next = hold_active_reg;
        hold_start_next  = hold_start_reg;
        last_sec_next    = last_sec_reg;
        ev               = dlp_pkg::EV_NONE;
        sec              = '0;
        priority if (stage.portal_active) begin
            hold_active_next = 1'b0;
            hold_start_next  = '0;
            last_sec_next    = '0;
        end else if (!stage.stable_level) begin
            if (hold_active_reg) begin
                ev  = dlp_pkg::EV_RELEASE;
                sec = held;
            end
            hold_active_next = 1'b0;
            hold_start_next  = '0;
            last_sec_next    = '0;
        end else if (!hold_active_reg) begin
            hold_active_next = 1'b1;
            hold_start_next  = stage.now_ms;
            last_sec_next    = '0;
            ev               = dlp_pkg::EV_PRESS;
        end else if (next_sec > {1'b0, hold_seconds} || next_sec > {1'b0, held}) begin
            // nothing new this poll
        end else if (next_sec[dlp_pkg::SEC_W-1:0] == hold_seconds) begin
            hold_active_next = 1'b0;
            hold_start_next  = '0;
            last_sec_next    = '0;
            ev               = dlp_pkg::EV_PORTAL;
            sec              = next_sec[dlp_pkg::SEC_W-1:0];
        end else begin
            last_sec_next = next_sec[dlp_pkg::SEC_W-1:0];
            ev            = dlp_pkg::EV_SECOND;
            sec           = next_sec[dlp_pkg::SEC_W-1:0];
        end
    end

    assign result.event_code   = ev;
    assign result.second_value = sec;
    assign result.stable_level = stage.stable_level;
    assign hold_start          = hold_start_reg;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_active_reg   <= 1'b0;
            hold_start_reg    <= '0;
            last_sec_reg      <= '0;
            press_started_reg <= 1'b0;
        end else if (fire) begin
            hold_active_reg   <= hold_active_next;
            hold_start_reg    <= hold_start_next;
            last_sec_reg      <= last_sec_next;
            press_started_reg <= (ev == dlp_pkg::EV_PRESS);
        end
    end

endmodule

// ----- rtl/dlp_checker.sv -----
// ----------------------------------------------------------------------------
// dlp_checker
// Port-level checks for the debounced long-press detector, bound to the top
// level.
// ----------------------------------------------------------------------------
module dlp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dlp_pkg::M_DATA_W-1:0]    m_tdata
);

    logic       in_xact;
    logic       out_xact;
    logic [2:0] inflight_reg;
    logic [2:0] code;
    logic [7:0] second;
    logic       level;

    assign in_xact  = s_tvalid && s_tready;
    assign out_xact = m_tvalid && m_tready;
    assign code     = m_tdata[2:0];
    assign second   = m_tdata[10:3];
    assign level    = m_tdata[11];

    // polls accepted but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + 3'(in_xact) - 3'(out_xact);
        end
    end

    // no result is left over from before reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // pipe holds at most three polls, and never answers more than it took
    a_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd3 && (!m_tvalid || inflight_reg != 3'd0))
        else $error("poll count out of step with results");

    // hold events agree with the debounced level
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (code == dlp_pkg::EV_PRESS || code == dlp_pkg::EV_SECOND ||
                     code == dlp_pkg::EV_PORTAL) |-> level)
        else $error("hold event while released");

    // second value is zero for no event and press start
    a_second: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (code == dlp_pkg::EV_NONE || code == dlp_pkg::EV_PRESS) |-> second == 8'd0)
        else $error("second value on an event that carries none");

endmodule

bind debounced_long_press_detector dlp_checker u_dlp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// ----- tb/debounced_long_press_detector_tb.sv -----
// ----------------------------------------------------------------------------
// debounced_long_press_detector_tb
// Self-checking bench for the debounced long-press detector. Polls are driven
// on the input stream, and every accepted poll is run through a behavioral
// copy of the debouncer and hold tracker. Every result transaction is
// compared field by field with the oldest prediction. A short directed run is
// followed by random press, bounce, portal and noise sequences under several
// debounce and hold settings, with random idling on both streams, one long
// output hold-off and drains between settings.
// ----------------------------------------------------------------------------
module debounced_long_press_detector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          PARK_CYCLES  = 200;
    localparam int          CYCLE_LIMIT  = 400000;

    // predicts one result per poll and checks results in order
    class press_event_board;
        logic [dlp_pkg::DEB_W-1:0]  debounce_ms;
        logic [dlp_pkg::SEC_W-1:0]  hold_secs;
        logic                       prev_raw;
        logic                       level;
        logic [dlp_pkg::TIME_W-1:0] changed_at;
        logic                       holding;
        logic [dlp_pkg::TIME_W-1:0] hold_start;
        logic [dlp_pkg::SEC_W-1:0]  reported;
        dlp_pkg::result_t           pending_events[$];
        int                         mismatches;

        function new();
            debounce_ms = dlp_pkg::DEBOUNCE_RESET;
            hold_secs   = dlp_pkg::HOLD_SECONDS_RESET;
            prev_raw    = 1'b0;
            level       = 1'b0;
            changed_at  = '0;
            mismatches  = 0;
            clear_hold();
        endfunction

        function void clear_hold();
            holding    = 1'b0;
            hold_start = '0;
            reported   = '0;
        endfunction

        function void set_register(logic [dlp_pkg::CFG_AW-1:0] addr,
                                   logic [dlp_pkg::CFG_DW-1:0] value);
            if (addr == dlp_pkg::CFG_DEBOUNCE_TIME)
                debounce_ms = value[dlp_pkg::DEB_W-1:0];
            else if (addr == dlp_pkg::CFG_HOLD_SECONDS)
                hold_secs = value[dlp_pkg::SEC_W-1:0];
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        // work out the result of one accepted poll
        function void note_poll(logic [dlp_pkg::TIME_W-1:0] now, logic raw, logic portal);
            dlp_pkg::result_t           r;
            logic [dlp_pkg::TIME_W-1:0] since_change;
            logic [dlp_pkg::TIME_W-1:0] since_start;
            logic [dlp_pkg::SEC_W-1:0]  held;
            logic [dlp_pkg::SEC_W:0]    next_sec;
            r.event_code   = dlp_pkg::EV_NONE;
            r.second_value = '0;
            if (portal) begin
                // debouncer frozen, hold tracking dropped
                clear_hold();
            end else begin
                since_change = now - changed_at;
                if (raw != prev_raw) begin
                    prev_raw   = raw;
                    changed_at = now;
                end else if (since_change >= {16'd0, debounce_ms}) begin
                    level = raw;
                end
                since_start = now - hold_start;
                held = dlp_pkg::SEC_W'(since_start / MS_PER_SEC);
                if (!level) begin
                    if (holding) begin
                        r.event_code   = dlp_pkg::EV_RELEASE;
                        r.second_value = held;
                    end
                    clear_hold();
                end else if (!holding) begin
                    holding      = 1'b1;
                    hold_start   = now;
                    reported     = '0;
                    r.event_code = dlp_pkg::EV_PRESS;
                end else begin
                    next_sec = {1'b0, reported} + 9'd1;
                    if (!(next_sec > {1'b0, hold_secs} || next_sec > {1'b0, held})) begin
                        if (next_sec == {1'b0, hold_secs}) begin
                            clear_hold();
                            r.event_code = dlp_pkg::EV_PORTAL;
                        end else begin
                            reported     = next_sec[dlp_pkg::SEC_W-1:0];
                            r.event_code = dlp_pkg::EV_SECOND;
                        end
                        r.second_value = next_sec[dlp_pkg::SEC_W-1:0];
                    end
                end
            end
            r.stable_level = level;
            pending_events.push_back(r);
        endfunction

        // compare one result transaction with the oldest prediction
        function void check_result(logic [dlp_pkg::M_DATA_W-1:0] data);
            dlp_pkg::result_t got;
            dlp_pkg::result_t exp;
            got = data[$bits(dlp_pkg::result_t)-1:0];
            if (pending_events.size() == 0) begin
                $error("result %h with no poll outstanding", data);
                mismatches++;
                return;
            end
            exp = pending_events.pop_front();
            if (got.event_code !== exp.event_code) begin
                $error("event_code: expected %0d, got %0d", exp.event_code, got.event_code);
                mismatches++;
            end
            if (got.second_value !== exp.second_value) begin
                $error("second_value: expected %0d, got %0d",
                       exp.second_value, got.second_value);
                mismatches++;
            end
            if (got.stable_level !== exp.stable_level) begin
                $error("stable_level: expected %0d, got %0d",
                       exp.stable_level, got.stable_level);
                mismatches++;
            end
            if (data[dlp_pkg::M_DATA_W-1:$bits(dlp_pkg::result_t)] !== '0) begin
                $error("tdata padding: expected 0, got %h",
                       data[dlp_pkg::M_DATA_W-1:$bits(dlp_pkg::result_t)]);
                mismatches++;
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [dlp_pkg::S_DATA_W-1:0]   s_tdata;    // now_ms[31:0], raw_pressed, portal_active
    logic                           m_tvalid;
    logic                           m_tready;
    logic [dlp_pkg::M_DATA_W-1:0]   m_tdata;    // event_code[2:0], second_value[7:0], stable_level
    logic                           cfg_wr_en;
    logic [dlp_pkg::CFG_AW-1:0]     cfg_addr;
    logic [dlp_pkg::CFG_DW-1:0]     cfg_wdata;

    press_event_board               press_board = new();
    logic [dlp_pkg::TIME_W-1:0]     clock_ms;
    int                             polls_sent;
    int                             cycle_count;
    bit                             snd_idle;
    bit                             rcv_idle;
    bit                             park_req;

    debounced_long_press_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            press_board.check_result(m_tdata);
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int stall;
        m_tready = 1'b0;
        rcv_idle = 1'b1;
        forever begin
            @(negedge aclk);
            if (park_req) begin
                m_tready <= 1'b0;
                repeat (PARK_CYCLES) @(negedge aclk);
                park_req = 1'b0;
            end else begin
                if ($urandom_range(0, 39) == 0)
                    rcv_idle = !rcv_idle;
                stall = rcv_idle ? $urandom_range(0, 16) : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && !park_req);
        end
    end

    // offer one poll and wait for the transaction; returns at a falling edge
    task automatic send_poll(input logic [dlp_pkg::TIME_W-1:0] now, input logic raw,
                             input logic portal);
        int gap;
        if ($urandom_range(0, 39) == 0)
            snd_idle = !snd_idle;
        gap = (snd_idle && !park_req) ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, portal, raw, now};
        do @(posedge aclk); while (!s_tready);
        press_board.note_poll(now, raw, portal);
        polls_sent++;
        @(negedge aclk);
    endtask

    task automatic poll_after(input int unsigned dt, input logic raw, input logic portal);
        clock_ms = clock_ms + dt;
        send_poll(clock_ms, raw, portal);
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (press_board.outstanding() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [dlp_pkg::CFG_AW-1:0] addr,
                             input logic [dlp_pkg::CFG_DW-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        press_board.set_register(addr, value);
    endtask

    task automatic apply_setting(input int unsigned deb, input int unsigned hold);
        settle();
        write_reg(dlp_pkg::CFG_DEBOUNCE_TIME, dlp_pkg::CFG_DW'(deb));
        write_reg(dlp_pkg::CFG_HOLD_SECONDS, dlp_pkg::CFG_DW'(hold));
    endtask

    // step around the debounce boundary
    function automatic int unsigned settle_step(input int unsigned deb);
        case ($urandom_range(0, 3))
            0:       return (deb == 0) ? 0 : deb - 1;
            1:       return deb;
            default: return deb + $urandom_range(0, 200);
        endcase
    endfunction

    // mostly sub-second steps, sometimes very long gaps
    function automatic int unsigned hold_step();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(2000, 400000);
        return $urandom_range(300, 1400);
    endfunction

    // one random sequence: noise, portal stretch, or a bounced press and release
    task automatic press_episode();
        int          kind;
        int          bounces;
        int          steady;
        int unsigned deb;
        int unsigned hold;
        deb  = press_board.debounce_ms;
        hold = press_board.hold_secs;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) begin
                clock_ms = $urandom;
                send_poll(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end else if (kind == 1) begin
            repeat ($urandom_range(1, 3))
                poll_after($urandom_range(0, 3000), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            // contact bounce, then settle pressed
            bounces = $urandom_range(0, 4);
            for (int i = 0; i < bounces; i++)
                poll_after($urandom_range(0, 5), 1'(i % 2 == 0), 1'b0);
            poll_after(settle_step(deb), 1'b1, 1'b0);
            poll_after(settle_step(deb), 1'b1, 1'b0);
            // hold, now and then interrupted by the portal
            if ($urandom_range(0, 15) == 0)
                steady = hold + 2;
            else
                steady = $urandom_range(1, (hold < 10) ? hold + 2 : 12);
            for (int i = 0; i < steady; i++)
                poll_after(hold_step(), 1'b1, 1'($urandom_range(0, 24) == 0));
            // bounce out and release for sure
            bounces = $urandom_range(0, 3);
            for (int i = 0; i < bounces; i++)
                poll_after($urandom_range(0, 5), 1'(i % 2 == 1), 1'b0);
            poll_after(settle_step(deb), 1'b0, 1'b0);
            poll_after(settle_step(deb), 1'b0, 1'b0);
            poll_after(deb + $urandom_range(1, 50), 1'b0, 1'b0);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        snd_idle  = 1'b1;
        park_req  = 1'b0;
        polls_sent  = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, wrap of the timestamp, debounce edge
        send_poll(32'd0, 1'b0, 1'b0);
        send_poll(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_poll(32'd48, 1'b1, 1'b0);
        send_poll(32'd49, 1'b1, 1'b0);
        // first second, repeat poll, then a long gap with truncated seconds
        send_poll(32'd1049, 1'b1, 1'b0);
        send_poll(32'd1049, 1'b1, 1'b0);
        send_poll(32'd900049, 1'b1, 1'b0);
        // portal clears the hold and freezes the debouncer
        send_poll(32'd900050, 1'b0, 1'b1);
        send_poll(32'd900051, 1'b1, 1'b0);
        // one second per poll up to the portal request
        repeat (5) send_poll(32'd905051, 1'b1, 1'b0);
        send_poll(32'd905100, 1'b0, 1'b0);
        send_poll(32'd905200, 1'b0, 1'b0);
        // early release after two seconds
        send_poll(32'd905300, 1'b1, 1'b0);
        send_poll(32'd905350, 1'b1, 1'b0);
        send_poll(32'd907500, 1'b1, 1'b0);
        send_poll(32'd907600, 1'b0, 1'b0);
        send_poll(32'd907700, 1'b0, 1'b0);
        clock_ms = 32'd907700;

        // zero debounce, portal at the first second
        apply_setting(0, 1);
        while (polls_sent < 120) press_episode();

        // widest debounce, longest hold
        apply_setting(65535, 255);
        while (polls_sent < 230) press_episode();

        // hold left running across a lowered hold setting
        apply_setting(10, 10);
        while (polls_sent < 320) press_episode();
        poll_after(1000, 1'b0, 1'b0);
        poll_after(20, 1'b0, 1'b0);
        poll_after(20, 1'b0, 1'b0);
        poll_after(5, 1'b1, 1'b0);
        poll_after(20, 1'b1, 1'b0);
        repeat (4) poll_after(1000, 1'b1, 1'b0);
        settle();
        write_reg(dlp_pkg::CFG_HOLD_SECONDS, dlp_pkg::CFG_DW'(2));
        repeat (3) poll_after(1000, 1'b1, 1'b0);
        poll_after(5, 1'b0, 1'b0);
        poll_after(20, 1'b0, 1'b0);
        while (polls_sent < 440) press_episode();

        // hold zero: presses tracked until release, no second or portal request reported
        apply_setting(50, 0);
        while (polls_sent < 530) press_episode();

        // output held off while polls keep coming
        apply_setting(1234, 7);
        park_req = 1'b1;
        while (park_req) press_episode();
        while (polls_sent < 600) press_episode();

        settle();
        if (press_board.mismatches == 0 && press_board.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- debounced_long_press_detector.f -----
rtl/dlp_pkg.sv
rtl/dlp_debounce.sv
rtl/dlp_sec_div.sv
rtl/dlp_hold_ctrl.sv
rtl/debounced_long_press_detector.sv
rtl/dlp_checker.sv
tb/debounced_long_press_detector_tb.sv
